FILE: hdl/bdmls_pkg.sv
package bdmls_pkg;

	// Default sizing
	localparam int unsigned MEM_BYTES_DEF        = 65536;
	localparam int unsigned MAX_BURST_DEF        = 16;
	localparam int unsigned WRITE_FIFO_DEPTH_DEF = 16;

	// Fixed field widths
	localparam int unsigned OP_W    = 2;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned LEN_W   = 5;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned TAG_W   = 16;
	localparam int unsigned RKIND_W = 2;
	localparam int unsigned BEAT_W  = 4;

	// Byte stride between beats
	localparam int unsigned BEAT_STRIDE = 4;

	// Operation codes
	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WREQ  = 2'd1;
	localparam logic [OP_W-1:0] OP_WDATA = 2'd2;

	// Load kinds (anything above LD_W acts as a word load)
	localparam logic [KIND_W-1:0] LD_B  = 3'd0;
	localparam logic [KIND_W-1:0] LD_BU = 3'd1;
	localparam logic [KIND_W-1:0] LD_H  = 3'd2;
	localparam logic [KIND_W-1:0] LD_HU = 3'd3;
	localparam logic [KIND_W-1:0] LD_W  = 3'd4;

	// Store kinds (anything above ST_W acts as a word store)
	localparam logic [KIND_W-1:0] ST_B = 3'd0;
	localparam logic [KIND_W-1:0] ST_H = 3'd1;
	localparam logic [KIND_W-1:0] ST_W = 3'd2;

	// Store size codes kept in the write queue
	localparam logic [1:0] SZ_B = 2'd0;
	localparam logic [1:0] SZ_H = 2'd1;
	localparam logic [1:0] SZ_W = 2'd2;

	// Result kinds
	localparam logic [RKIND_W-1:0] RES_READ     = 2'd0;
	localparam logic [RKIND_W-1:0] RES_ORPHAN   = 2'd1;
	localparam logic [RKIND_W-1:0] RES_OVERFLOW = 2'd2;

	// Last byte lane of an access, from its size code
	function automatic logic [1:0] size_last_lane(input logic [1:0] sz);
		logic [1:0] r;
		unique case (sz)
			SZ_B:    r = 2'd0;
			SZ_H:    r = 2'd1;
			default: r = 2'd3;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/burst_data_memory_load_store_core.sv
// Byte-addressed little-endian data memory with burst loads and queued stores.
// Slave stream: one word per request or store-data beat; tuser holds the op
// (read request, write request, write data). Master stream: one word per
// result; tuser holds the result kind, tlast marks the final beat of a burst.
// Read request of N beats: beat k reads base + 4k, extended per load kind.
// Write request of N beats: N address/size entries go into the write queue,
// or a single overflow result is returned if the queue lacks room.
// Write data: pops the oldest entry and stores 1, 2 or 4 bytes, or returns
// an orphan result if the queue is empty.
// Timing: one byte-wide memory port does every access, one byte per cycle.
// A request first reduces its base address modulo MEM_BYTES by repeated
// conditional subtraction. A read beat then reads its bytes one at a time,
// waits for the last byte and emits its result; a write beat queues one entry;
// store data pops the oldest entry and writes its bytes one at a time. s_axis_tready is high only while idle.
// A stalled master holds the sequencer at the pending result; the result
// register frees as soon as it is taken. Reset empties the queue and the
// result register; memory contents are undefined until written.
module burst_data_memory_load_store_core #(
	parameter int unsigned MEM_BYTES        = bdmls_pkg::MEM_BYTES_DEF,
	parameter int unsigned MAX_BURST        = bdmls_pkg::MAX_BURST_DEF,
	parameter int unsigned WRITE_FIFO_DEPTH = bdmls_pkg::WRITE_FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// access_kind[2:0], base_address[18:3], burst_length[23:19],
	// write_value[55:24], request_tag[71:56]
	input  logic [71:0] s_axis_tdata,
	// op[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_value[31:0], response_tag[47:32], beat_index[51:48], zero pad[55:52]
	output logic [55:0] m_axis_tdata,
	// result_kind[1:0]
	output logic [1:0]  m_axis_tuser,
	// last_beat
	output logic        m_axis_tlast
);
	import bdmls_pkg::*;

	localparam int unsigned AW        = $clog2(MEM_BYTES);
	localparam int unsigned CW        = $clog2(MAX_BURST + 1);
	localparam int unsigned PW        = (WRITE_FIFO_DEPTH > 1) ? $clog2(WRITE_FIFO_DEPTH) : 1;
	localparam int unsigned QW        = $clog2(WRITE_FIFO_DEPTH + 1);
	localparam int unsigned RED_STEPS = (MEM_BYTES >= 65536) ? 1 : 17 - AW;
	localparam int unsigned EW        = AW + 2;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_REDUCE = 4'd1;
	localparam logic [3:0] ST_READ   = 4'd2;
	localparam logic [3:0] ST_RWAIT  = 4'd3;
	localparam logic [3:0] ST_EMIT   = 4'd4;
	localparam logic [3:0] ST_ENQ    = 4'd5;
	localparam logic [3:0] ST_WLOAD  = 4'd6;
	localparam logic [3:0] ST_WRITE  = 4'd7;
	localparam logic [3:0] ST_RESP   = 4'd8;

	// Input word fields
	logic [OP_W-1:0]   in_op;
	logic [KIND_W-1:0] in_kind;
	logic [ADDR_W-1:0] in_base;
	logic [LEN_W-1:0]  in_len;
	logic [DATA_W-1:0] in_wval;
	logic [TAG_W-1:0]  in_tag;

	assign in_op   = s_axis_tuser;
	assign in_kind = s_axis_tdata[2:0];
	assign in_base = s_axis_tdata[18:3];
	assign in_len  = s_axis_tdata[23:19];
	assign in_wval = s_axis_tdata[55:24];
	assign in_tag  = s_axis_tdata[71:56];

	// Storage
	logic [7:0]    mem [MEM_BYTES];
	logic [7:0]    mem_rd_q;
	logic [EW-1:0] fifo_mem [WRITE_FIFO_DEPTH];
	logic [EW-1:0] fifo_rd_q;

	// Control state
	logic [3:0]    state_q;
	logic [PW-1:0] head_q, tail_q;
	logic [QW-1:0] count_q;
	logic [CW-1:0] n_q, k_q;
	logic [3:0]    step_q;
	logic [1:0]    j_q, nb_last_q, lane_q;
	logic          rd_pend_q;
	logic          out_valid_q;

	// Payload state
	logic [OP_W-1:0]    op_q;
	logic [KIND_W-1:0]  kind_q;
	logic [TAG_W-1:0]   tag_q;
	logic [DATA_W-1:0]  wval_q;
	logic [ADDR_W-1:0]  r_q;
	logic [AW-1:0]      beat_addr_q, byte_addr_q;
	logic [1:0]         size_q;
	logic [DATA_W-1:0]  acc_q;
	logic [RKIND_W-1:0] resp_kind_q;
	logic [RKIND_W-1:0] out_kind_q;
	logic [DATA_W-1:0]  out_val_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic [BEAT_W-1:0]  out_beat_q;
	logic               out_last_q;

	logic in_acc, out_free;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Burst length: zero means one beat, saturate at MAX_BURST
	logic [6:0]    len_ext;
	logic [CW-1:0] len_clamp;
	always_comb begin
		len_ext = 7'(in_len);
		if (len_ext == 7'd0) begin
			len_clamp = CW'(1);
		end else if (len_ext > 7'(MAX_BURST)) begin
			len_clamp = CW'(MAX_BURST);
		end else begin
			len_clamp = CW'(len_ext);
		end
	end

	// Room check for a write request
	logic [9:0] need;
	logic       no_room;
	assign need    = 10'(count_q) + 10'(len_clamp);
	assign no_room = need > 10'(WRITE_FIFO_DEPTH);

	// Access sizes from kind codes
	logic [1:0] st_size_in, ld_size_in;
	always_comb begin
		priority if (in_kind == ST_B) begin
			st_size_in = SZ_B;
		end else if (in_kind == ST_H) begin
			st_size_in = SZ_H;
		end else begin
			st_size_in = SZ_W;
		end
		priority if (in_kind == LD_B || in_kind == LD_BU) begin
			ld_size_in = SZ_B;
		end else if (in_kind == LD_H || in_kind == LD_HU) begin
			ld_size_in = SZ_H;
		end else begin
			ld_size_in = SZ_W;
		end
	end

	// Shared address unit: remainder step, beat stride, byte increment
	logic [31:0]   divisor;
	logic [ADDR_W-1:0] r_next;
	logic [AW:0]   bsum;
	logic [AW-1:0] beat_next, byte_next;
	logic [AW-1:0] r_wrapped;
	assign divisor   = 32'(MEM_BYTES) << step_q;
	assign r_next    = (32'(r_q) >= divisor) ? ADDR_W'(32'(r_q) - divisor) : r_q;
	assign r_wrapped = AW'(r_next);
	assign bsum      = {1'b0, beat_addr_q} + (AW+1)'(BEAT_STRIDE);
	assign beat_next = (bsum >= (AW+1)'(MEM_BYTES)) ? AW'(bsum - (AW+1)'(MEM_BYTES))
	                                                : AW'(bsum);
	assign byte_next = (byte_addr_q == AW'(MEM_BYTES - 1)) ? '0 : byte_addr_q + AW'(1);

	// Load extension
	logic [DATA_W-1:0] ld_val;
	always_comb begin
		priority if (kind_q == LD_B) begin
			ld_val = {{24{acc_q[7]}}, acc_q[7:0]};
		end else if (kind_q == LD_BU) begin
			ld_val = {24'd0, acc_q[7:0]};
		end else if (kind_q == LD_H) begin
			ld_val = {{16{acc_q[15]}}, acc_q[15:0]};
		end else if (kind_q == LD_HU) begin
			ld_val = {16'd0, acc_q[15:0]};
		end else begin
			ld_val = acc_q;
		end
	end

	logic beat_done;
	assign beat_done = (k_q == n_q - CW'(1));

	// Sequencer and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			n_q         <= '0;
			k_q         <= '0;
			step_q      <= '0;
			j_q         <= '0;
			nb_last_q   <= '0;
			lane_q      <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= 1'b0;
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						n_q    <= len_clamp;
						k_q    <= '0;
						j_q    <= '0;
						step_q <= 4'(RED_STEPS - 1);
						unique case (in_op)
							OP_READ: begin
								nb_last_q <= size_last_lane(ld_size_in);
								state_q   <= ST_REDUCE;
							end
							OP_WREQ: begin
								state_q <= no_room ? ST_RESP : ST_REDUCE;
							end
							OP_WDATA: begin
								state_q <= (count_q == '0) ? ST_RESP : ST_WLOAD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_REDUCE: begin
					step_q <= step_q - 4'd1;
					if (step_q == 4'd0) begin
						state_q <= (op_q == OP_READ) ? ST_READ : ST_ENQ;
					end
				end
				ST_READ: begin
					rd_pend_q <= 1'b1;
					lane_q    <= j_q;
					j_q       <= j_q + 2'd1;
					if (j_q == nb_last_q) begin
						state_q <= ST_RWAIT;
					end
				end
				ST_RWAIT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						j_q         <= '0;
						k_q         <= k_q + CW'(1);
						state_q     <= beat_done ? ST_IDLE : ST_READ;
					end
				end
				ST_ENQ: begin
					tail_q  <= (tail_q == PW'(WRITE_FIFO_DEPTH - 1)) ? '0 : tail_q + PW'(1);
					count_q <= count_q + QW'(1);
					k_q     <= k_q + CW'(1);
					if (beat_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WLOAD: begin
					head_q    <= (head_q == PW'(WRITE_FIFO_DEPTH - 1)) ? '0 : head_q + PW'(1);
					count_q   <= count_q - QW'(1);
					nb_last_q <= size_last_lane(fifo_rd_q[EW-1:AW]);
					j_q       <= '0;
					state_q   <= ST_WRITE;
				end
				ST_WRITE: begin
					j_q <= j_q + 2'd1;
					if (j_q == nb_last_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			acc_q[lane_q*8 +: 8] <= mem_rd_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					op_q   <= in_op;
					kind_q <= in_kind;
					tag_q  <= in_tag;
					wval_q <= in_wval;
					r_q    <= in_base;
					size_q <= st_size_in;
					resp_kind_q <= (in_op == OP_WREQ) ? RES_OVERFLOW : RES_ORPHAN;
				end
			end
			ST_REDUCE: begin
				r_q <= r_next;
				if (step_q == 4'd0) begin
					beat_addr_q <= r_wrapped;
					byte_addr_q <= r_wrapped;
				end
			end
			ST_READ: begin
				byte_addr_q <= byte_next;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_kind_q  <= RES_READ;
					out_val_q   <= ld_val;
					out_tag_q   <= tag_q;
					out_beat_q  <= BEAT_W'(k_q);
					out_last_q  <= beat_done;
					beat_addr_q <= beat_next;
					byte_addr_q <= beat_next;
				end
			end
			ST_ENQ: begin
				beat_addr_q <= beat_next;
			end
			ST_WLOAD: begin
				byte_addr_q <= fifo_rd_q[AW-1:0];
			end
			ST_WRITE: begin
				byte_addr_q <= byte_next;
			end
			ST_RESP: begin
				if (out_free) begin
					out_kind_q <= resp_kind_q;
					out_val_q  <= '0;
					out_tag_q  <= tag_q;
					out_beat_q <= '0;
					out_last_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Byte memory: at most one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			mem[byte_addr_q] <= wval_q[j_q*8 +: 8];
		end
		mem_rd_q <= mem[byte_addr_q];
	end

	// Write queue memory: entry is {size code, wrapped address}
	always_ff @(posedge clk) begin
		if (state_q == ST_ENQ) begin
			fifo_mem[tail_q] <= {size_q, beat_addr_q};
		end
		fifo_rd_q <= fifo_mem[head_q];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_beat_q, out_tag_q, out_val_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

FILE: bench/burst_data_memory_load_store_core_tb.sv
`timescale 1ns / 1ps

module burst_data_memory_load_store_core_tb;
	import bdmls_pkg::*;

	// Op and kind codes the package leaves unnamed
	localparam logic [OP_W-1:0]   OP_NONE    = 2'd3;
	localparam logic [KIND_W-1:0] ST_UNKNOWN = 3'd5;
	localparam logic [KIND_W-1:0] LD_UNKNOWN = 3'd6;

	localparam int unsigned ITEM_TARGET = 370;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [KIND_W-1:0] access_kind;
		logic [ADDR_W-1:0] base_address;
		logic [LEN_W-1:0]  burst_length;
		logic [DATA_W-1:0] write_value;
		logic [TAG_W-1:0]  request_tag;
	} mem_cmd_t;

	typedef struct packed {
		logic [RKIND_W-1:0] result_kind;
		logic [DATA_W-1:0]  read_value;
		logic [TAG_W-1:0]   response_tag;
		logic [BEAT_W-1:0]  beat_index;
		logic               last_beat;
	} mem_resp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [1:0]        size;
	} store_slot_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// Pending commands and the results they should produce
	mem_cmd_t    cmd_backlog[$];
	mem_resp_t   resp_due[$];

	// Predicted block state
	logic [7:0]  model_mem [0:MEM_BYTES_DEF-1];
	store_slot_t model_slots[$];

	// Stimulus planning state: queued store slots and bytes known to be written
	store_slot_t plan_slots[$];
	bit          plan_written [0:MEM_BYTES_DEF-1];
	int unsigned items_planned = 0;

	mem_cmd_t    offered_cmd;
	int unsigned sent_count = 0;
	mem_resp_t   seen_resp;
	mem_resp_t   want_resp;
	int unsigned resp_seen;
	int unsigned hold_cycles;
	bit          hold_done;
	int unsigned mismatches = 0;

	burst_data_memory_load_store_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic int unsigned beat_count(input logic [LEN_W-1:0] len);
		if (len == 0)
			return 1;
		if (len > MAX_BURST_DEF)
			return MAX_BURST_DEF;
		return 32'(len);
	endfunction

	function automatic logic [1:0] load_size(input logic [KIND_W-1:0] kind);
		case (kind)
			LD_B, LD_BU: return SZ_B;
			LD_H, LD_HU: return SZ_H;
			default:     return SZ_W;
		endcase
	endfunction

	function automatic logic [1:0] store_size(input logic [KIND_W-1:0] kind);
		case (kind)
			ST_B:    return SZ_B;
			ST_H:    return SZ_H;
			default: return SZ_W;
		endcase
	endfunction

	function automatic int unsigned size_bytes(input logic [1:0] sz);
		case (sz)
			SZ_B:    return 1;
			SZ_H:    return 2;
			default: return 4;
		endcase
	endfunction

	// Expected results of one accepted command; updates the predicted memory and queue
	function automatic void predict_memory_op(input mem_cmd_t c);
		int unsigned n;
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] w;
		mem_resp_t r;
		store_slot_t s;
		n = beat_count(c.burst_length);
		r = '0;
		r.response_tag = c.request_tag;
		r.last_beat = 1'b1;
		case (c.op)
			OP_READ: begin
				for (int unsigned k = 0; k < n; k++) begin
					// gather four bytes little-endian, wrapping at the top of memory
					for (int unsigned b = 0; b < 4; b++) begin
						a = c.base_address + ADDR_W'(BEAT_STRIDE * k + b);
						w[8*b +: 8] = model_mem[a];
					end
					case (c.access_kind)
						LD_B:    r.read_value = {{24{w[7]}}, w[7:0]};
						LD_BU:   r.read_value = {24'd0, w[7:0]};
						LD_H:    r.read_value = {{16{w[15]}}, w[15:0]};
						LD_HU:   r.read_value = {16'd0, w[15:0]};
						default: r.read_value = w;
					endcase
					r.result_kind = RES_READ;
					r.beat_index = BEAT_W'(k);
					r.last_beat = (k + 1 == n);
					resp_due.push_back(r);
				end
			end
			OP_WREQ: begin
				// all beats fit or the whole request is dropped
				if (model_slots.size() + n > WRITE_FIFO_DEPTH_DEF) begin
					r.result_kind = RES_OVERFLOW;
					resp_due.push_back(r);
				end else begin
					for (int unsigned k = 0; k < n; k++) begin
						s.addr = c.base_address + ADDR_W'(BEAT_STRIDE * k);
						s.size = store_size(c.access_kind);
						model_slots.push_back(s);
					end
				end
			end
			OP_WDATA: begin
				if (model_slots.size() == 0) begin
					r.result_kind = RES_ORPHAN;
					resp_due.push_back(r);
				end else begin
					s = model_slots.pop_front();
					for (int unsigned b = 0; b < size_bytes(s.size); b++) begin
						a = s.addr + ADDR_W'(b);
						model_mem[a] = c.write_value[8*b +: 8];
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic mem_cmd_t make_cmd(input logic [OP_W-1:0] op,
		input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] base,
		input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] value);
		mem_cmd_t c;
		c.op = op;
		c.access_kind = kind;
		c.base_address = base;
		c.burst_length = len;
		c.write_value = value;
		c.request_tag = TAG_W'($urandom);
		return c;
	endfunction

	// Queue a command and track which bytes it will leave written
	function automatic void queue_cmd(input mem_cmd_t c);
		int unsigned n;
		store_slot_t s;
		logic [ADDR_W-1:0] a;
		n = beat_count(c.burst_length);
		if (c.op == OP_WREQ && plan_slots.size() + n <= WRITE_FIFO_DEPTH_DEF) begin
			for (int unsigned k = 0; k < n; k++) begin
				s.addr = c.base_address + ADDR_W'(BEAT_STRIDE * k);
				s.size = store_size(c.access_kind);
				plan_slots.push_back(s);
			end
		end else if (c.op == OP_WDATA && plan_slots.size() != 0) begin
			s = plan_slots.pop_front();
			for (int unsigned b = 0; b < size_bytes(s.size); b++) begin
				a = s.addr + ADDR_W'(b);
				plan_written[a] = 1'b1;
			end
		end
		if (c.op != OP_NONE)
			items_planned++;
		cmd_backlog.push_back(c);
	endfunction

	// A load may only touch bytes that were stored before
	function automatic bit readable(input logic [KIND_W-1:0] kind,
		input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] a;
		for (int unsigned k = 0; k < beat_count(len); k++)
			for (int unsigned b = 0; b < size_bytes(load_size(kind)); b++) begin
				a = base + ADDR_W'(BEAT_STRIDE * k + b);
				if (!plan_written[a])
					return 1'b0;
			end
		return 1'b1;
	endfunction

	// Hot region straddling the wrap point
	function automatic logic [ADDR_W-1:0] window_addr();
		return 16'hFF80 + ADDR_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		if ($urandom_range(0, 9) < 7)
			return LEN_W'($urandom_range(1, 4));
		return LEN_W'($urandom_range(0, 31));
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			if (mismatches < 100)
				$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Stimulus, reset and end of run
	initial begin
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  len;
		int unsigned       roll;
		bit                found;
		int unsigned       cmd_total;

		// store data with nothing queued
		queue_cmd(make_cmd(OP_WDATA, ST_W, 16'h0000, 5'd1, 32'hFFFF_FFFF));
		// word burst across the top of memory
		queue_cmd(make_cmd(OP_WREQ, ST_W, 16'hFFF8, 5'd4, $urandom));
		queue_cmd(make_cmd(OP_WDATA, ST_B, 16'h1234, 5'd0, 32'h1234_8086));
		queue_cmd(make_cmd(OP_WDATA, ST_B, 16'hFFFF, 5'd31, 32'hFFFF_FFFF));
		queue_cmd(make_cmd(OP_WDATA, ST_B, 16'h0000, 5'd16, 32'h0000_7F00));
		queue_cmd(make_cmd(OP_WDATA, ST_B, 16'h8001, 5'd1, 32'h8000_0001));
		// halfword straddling the end of memory
		queue_cmd(make_cmd(OP_WREQ, ST_H, 16'hFFFF, 5'd1, $urandom));
		queue_cmd(make_cmd(OP_WDATA, ST_W, 16'h0000, 5'd1, 32'hABCD_55AA));
		queue_cmd(make_cmd(OP_WREQ, ST_B, 16'h0002, 5'd2, $urandom));
		queue_cmd(make_cmd(OP_WDATA, ST_W, 16'h0000, 5'd1, 32'h0000_00C3));
		queue_cmd(make_cmd(OP_WDATA, ST_W, 16'h0000, 5'd1, 32'h5A5A_5A7E));
		// unknown store kind, zero length
		queue_cmd(make_cmd(OP_WREQ, ST_UNKNOWN, 16'h0008, 5'd0, $urandom));
		queue_cmd(make_cmd(OP_WDATA, ST_W, 16'h0000, 5'd1, 32'hDEAD_BEEF));
		// every load kind over the wrapped region
		queue_cmd(make_cmd(OP_READ, LD_B, 16'hFFF8, 5'd5, $urandom));
		queue_cmd(make_cmd(OP_READ, LD_BU, 16'hFFF8, 5'd5, $urandom));
		queue_cmd(make_cmd(OP_READ, LD_H, 16'hFFFA, 5'd3, $urandom));
		queue_cmd(make_cmd(OP_READ, LD_HU, 16'hFFFF, 5'd1, $urandom));
		queue_cmd(make_cmd(OP_READ, LD_W, 16'hFFFE, 5'd3, $urandom));
		queue_cmd(make_cmd(OP_READ, LD_UNKNOWN, 16'hFFF8, 5'd0, $urandom));
		queue_cmd(make_cmd(OP_NONE, KIND_W'($urandom), ADDR_W'($urandom),
			LEN_W'($urandom), $urandom));
		// over-long request fills the queue exactly, the next one overflows
		queue_cmd(make_cmd(OP_WREQ, ST_W, 16'h0000, 5'd31, $urandom));
		queue_cmd(make_cmd(OP_WREQ, ST_B, 16'h0100, 5'd1, $urandom));

		// random mix: mostly requests followed by their data, some noise
		while (items_planned < ITEM_TARGET) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				case ($urandom_range(0, 2))
					0: queue_cmd(make_cmd(OP_NONE, KIND_W'($urandom), ADDR_W'($urandom),
						LEN_W'($urandom), $urandom));
					1: queue_cmd(make_cmd(OP_WDATA, KIND_W'($urandom), ADDR_W'($urandom),
						LEN_W'($urandom), $urandom));
					default: queue_cmd(make_cmd(OP_WREQ, KIND_W'($urandom),
						ADDR_W'($urandom), LEN_W'($urandom), $urandom));
				endcase
			end else if (plan_slots.size() != 0 && roll < 50) begin
				queue_cmd(make_cmd(OP_WDATA, KIND_W'($urandom), ADDR_W'($urandom),
					LEN_W'($urandom), $urandom));
			end else if (roll < 72) begin
				base = ($urandom_range(0, 9) < 8) ? window_addr() : ADDR_W'($urandom);
				queue_cmd(make_cmd(OP_WREQ, KIND_W'($urandom_range(0, 7)), base, pick_len(),
					$urandom));
			end else begin
				found = 1'b0;
				for (int t = 0; t < 16 && !found; t++) begin
					kind = KIND_W'($urandom_range(0, 7));
					base = window_addr();
					len = pick_len();
					found = readable(kind, base, len);
				end
				if (found)
					queue_cmd(make_cmd(OP_READ, kind, base, len, $urandom));
			end
		end
		cmd_total = cmd_backlog.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// every command accepted, then every predicted result seen
		while (sent_count < cmd_total)
			@(posedge clk);
		while (resp_due.size() != 0)
			@(posedge clk);
		// trailing store data can still be writing
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Driver: offer the next pending word, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_memory_op(offered_cmd);
				sent_count++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (cmd_backlog.size() != 0 &&
					((sent_count >= 150 && sent_count < 230) || $urandom_range(0, 99) >= 22)) begin
					offered_cmd = cmd_backlog.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {offered_cmd.request_tag, offered_cmd.write_value,
						offered_cmd.burst_length, offered_cmd.base_address,
						offered_cmd.access_kind};
					s_axis_tuser <= offered_cmd.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready: random stalls, one long hold-off, one stall-free stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= 0;
			hold_done <= 1'b0;
		end else if (hold_cycles != 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (!hold_done && resp_seen >= 120) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= 300;
			hold_done <= 1'b1;
		end else begin
			m_axis_tready <= (resp_seen >= 400 && resp_seen < 650) ||
				($urandom_range(0, 99) >= 22);
		end
	end

	// Monitor: compare each result word with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_seen <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			resp_seen <= resp_seen + 1;
			seen_resp.result_kind = m_axis_tuser;
			seen_resp.read_value = m_axis_tdata[31:0];
			seen_resp.response_tag = m_axis_tdata[47:32];
			seen_resp.beat_index = m_axis_tdata[51:48];
			seen_resp.last_beat = m_axis_tlast;
			if (resp_due.size() == 0) begin
				if (mismatches < 100)
					$display("%0t: result expected none got kind %h value %h tag %h", $time,
						seen_resp.result_kind, seen_resp.read_value, seen_resp.response_tag);
				mismatches++;
			end else begin
				want_resp = resp_due.pop_front();
				check_field("result_kind", 32'(want_resp.result_kind),
					32'(seen_resp.result_kind));
				check_field("read_value", want_resp.read_value, seen_resp.read_value);
				check_field("response_tag", 32'(want_resp.response_tag),
					32'(seen_resp.response_tag));
				check_field("beat_index", 32'(want_resp.beat_index),
					32'(seen_resp.beat_index));
				check_field("last_beat", 32'(want_resp.last_beat),
					32'(seen_resp.last_beat));
			end
		end
	end

endmodule
